FILE: design/jte_pkg.sv
package jte_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int PID_BITS      = 22;

  // Fixed widths of the request and response fields.
  localparam int PID_W   = 22;
  localparam int JID_W   = 16;
  localparam int SEL_W   = 4;
  localparam int SLOT_W  = 4;
  localparam int STATE_W = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] MODE_ADD      = 3'd0;
  localparam logic [2:0] MODE_DEL      = 3'd1;
  localparam logic [2:0] MODE_SET_PID  = 3'd2;
  localparam logic [2:0] MODE_SET_JID  = 3'd3;
  localparam logic [2:0] MODE_FIND_PID = 3'd4;
  localparam logic [2:0] MODE_FIND_JID = 3'd5;
  localparam logic [2:0] MODE_FG       = 3'd6;
  localparam logic [2:0] MODE_READ     = 3'd7;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_KEY  = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  localparam logic [STATE_W-1:0] ST_FG = 2'd1;

  // A classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]         mode;
    logic [PID_W-1:0]   pid;
    logic [JID_W-1:0]   jid;
    logic [STATE_W-1:0] nst;
    logic [SEL_W-1:0]   sel;
    logic               early;
    logic [1:0]         early_status;
  } cmd_t;

endpackage

FILE: design/jte_front.sv
module jte_front #(
  parameter int TableEntries = jte_pkg::TABLE_ENTRIES,
  parameter int PidBits      = jte_pkg::PID_BITS
) (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   mode_i,
  input  logic [jte_pkg::PID_W-1:0]    proc_id_i,
  input  logic [jte_pkg::JID_W-1:0]    job_num_i,
  input  logic [jte_pkg::STATE_W-1:0]  new_state_i,
  input  logic [jte_pkg::SEL_W-1:0]    slot_sel_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output jte_pkg::cmd_t                push_cmd_o
);

  logic [jte_pkg::PID_W-1:0] pid;
  logic                      sel_out_of_range;

  // Only the low PidBits bits of the process id take part.
  always_comb begin
    for (int b = 0; b < jte_pkg::PID_W; b++) begin
      pid[b] = proc_id_i[b] && (b < PidBits);
    end
  end

  assign sel_out_of_range = {28'd0, slot_sel_i} >= 32'(TableEntries);

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  // Requests that fail on their key alone, and reads of a slot out of range, never need the table.
  always_comb begin
    push_cmd_o.mode         = mode_i;
    push_cmd_o.pid          = pid;
    push_cmd_o.jid          = job_num_i;
    push_cmd_o.nst          = new_state_i;
    push_cmd_o.sel          = slot_sel_i;
    push_cmd_o.early        = 1'b0;
    push_cmd_o.early_status = jte_pkg::STAT_OK;
    unique case (mode_i) inside
      jte_pkg::MODE_ADD, jte_pkg::MODE_DEL, jte_pkg::MODE_SET_PID,
      jte_pkg::MODE_FIND_PID: begin
        if (pid == '0) begin
          push_cmd_o.early        = 1'b1;
          push_cmd_o.early_status = jte_pkg::STAT_KEY;
        end
      end
      jte_pkg::MODE_SET_JID, jte_pkg::MODE_FIND_JID: begin
        if (job_num_i == '0) begin
          push_cmd_o.early        = 1'b1;
          push_cmd_o.early_status = jte_pkg::STAT_KEY;
        end
      end
      jte_pkg::MODE_READ: begin
        if (sel_out_of_range) begin
          push_cmd_o.early        = 1'b1;
          push_cmd_o.early_status = jte_pkg::STAT_NONE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/jte_queue.sv
module jte_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  jte_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output jte_pkg::cmd_t pop_cmd_o
);

  localparam int PtrW = (jte_pkg::QUEUE_DEPTH > 1) ? $clog2(jte_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(jte_pkg::QUEUE_DEPTH + 1);

  jte_pkg::cmd_t       slots_q [jte_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != CntW'(jte_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(jte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(jte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/jte_back.sv
module jte_back #(
  parameter int TableEntries = jte_pkg::TABLE_ENTRIES,
  parameter int PidBits      = jte_pkg::PID_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  jte_pkg::cmd_t                cmd_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic [1:0]                   status_o,
  output logic [jte_pkg::PID_W-1:0]    res_pid_o,
  output logic [jte_pkg::JID_W-1:0]    res_jid_o,
  output logic [jte_pkg::STATE_W-1:0]  res_state_o,
  output logic [jte_pkg::SLOT_W-1:0]   res_slot_o
);

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int PidW = (PidBits < jte_pkg::PID_W) ? PidBits : jte_pkg::PID_W;
  localparam int JidW = jte_pkg::JID_W;
  localparam int StW  = jte_pkg::STATE_W;
  localparam int RowW = PidW + JidW + StW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RDSLOT = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // Table storage: one row per slot, plus a live bit per slot cleared at reset.
  logic [RowW-1:0]     mem [TableEntries];
  logic [TableEntries-1:0] live_q;

  logic [2:0]          state_q;
  jte_pkg::cmd_t       cmd_q;
  logic [CntW-1:0]     idx_q;
  logic                chk_vld_q;
  logic [IdxW-1:0]     chk_idx_q;
  logic                found_q;
  logic [IdxW-1:0]     hit_idx_q;
  logic [PidW-1:0]     hit_pid_q;
  logic [JidW-1:0]     hit_jid_q;
  logic [StW-1:0]      hit_st_q;
  logic [JidW-1:0]     max_jid_q;
  logic [JidW-1:0]     next_jid_q;
  logic [RowW-1:0]     rd_row_q;
  logic                rd_live_q;

  logic                pend_ok_q;
  logic [1:0]          pend_status_q;
  logic [PidW-1:0]     pend_pid_q;
  logic [JidW-1:0]     pend_jid_q;
  logic [StW-1:0]      pend_st_q;
  logic [IdxW-1:0]     pend_slot_q;

  logic                out_valid_q;
  logic                ok_q;
  logic [1:0]          status_q;
  logic [jte_pkg::PID_W-1:0]  res_pid_q;
  logic [JidW-1:0]     res_jid_q;
  logic [StW-1:0]      res_st_q;
  logic [jte_pkg::SLOT_W-1:0] res_slot_q;

  logic [IdxW-1:0]     rd_addr;
  logic                issue;
  logic [PidW-1:0]     ent_pid;
  logic [JidW-1:0]     ent_jid;
  logic [StW-1:0]      ent_st;
  logic                match;
  logic                hit_now;
  logic                last_now;
  logic                is_del;
  logic                mem_we;
  logic [RowW-1:0]     mem_wd;
  logic [JidW-1:0]     jid_inc;
  logic                out_free;
  logic                out_load;

  assign cmd_ready_o = state_q == S_IDLE;
  assign rd_addr     = (state_q == S_IDLE) ? IdxW'(cmd_i.sel) : idx_q[IdxW-1:0];
  assign issue       = (state_q == S_SCAN) && (idx_q < CntW'(TableEntries));

  // A slot that was never written, or was deleted, reads as all zero.
  assign ent_pid = rd_live_q ? rd_row_q[RowW-1 -: PidW] : '0;
  assign ent_jid = rd_live_q ? rd_row_q[StW +: JidW] : '0;
  assign ent_st  = rd_live_q ? rd_row_q[StW-1:0] : '0;

  always_comb begin
    unique case (cmd_q.mode) inside
      jte_pkg::MODE_ADD: match = ent_pid == '0;
      jte_pkg::MODE_DEL, jte_pkg::MODE_SET_PID, jte_pkg::MODE_FIND_PID:
        match = ent_pid == cmd_q.pid[PidW-1:0];
      jte_pkg::MODE_SET_JID, jte_pkg::MODE_FIND_JID: match = ent_jid == cmd_q.jid;
      jte_pkg::MODE_FG: match = ent_st == jte_pkg::ST_FG;
      default: match = 1'b0;
    endcase
  end

  assign hit_now  = chk_vld_q && match && !found_q;
  assign last_now = chk_vld_q && (chk_idx_q == IdxW'(TableEntries - 1));
  assign is_del   = cmd_q.mode == jte_pkg::MODE_DEL;
  assign jid_inc  = next_jid_q + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == S_DONE) && out_free;

  always_comb begin
    mem_we = 1'b0;
    mem_wd = {hit_pid_q, hit_jid_q, cmd_q.nst};
    if (state_q == S_APPLY) begin
      unique case (cmd_q.mode) inside
        jte_pkg::MODE_ADD: begin
          mem_we = 1'b1;
          mem_wd = {cmd_q.pid[PidW-1:0], next_jid_q, cmd_q.nst};
        end
        jte_pkg::MODE_SET_PID, jte_pkg::MODE_SET_JID: mem_we = 1'b1;
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[hit_idx_q] <= mem_wd;
    end
    rd_row_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= '0;
      idx_q         <= '0;
      chk_vld_q     <= 1'b0;
      chk_idx_q     <= '0;
      found_q       <= 1'b0;
      hit_idx_q     <= '0;
      hit_pid_q     <= '0;
      hit_jid_q     <= '0;
      hit_st_q      <= '0;
      max_jid_q     <= '0;
      next_jid_q    <= JidW'(1);
      live_q        <= '0;
      rd_live_q     <= 1'b0;
      pend_ok_q     <= 1'b0;
      pend_status_q <= jte_pkg::STAT_OK;
      pend_pid_q    <= '0;
      pend_jid_q    <= '0;
      pend_st_q     <= '0;
      pend_slot_q   <= '0;
      out_valid_q   <= 1'b0;
      ok_q          <= 1'b0;
      status_q      <= jte_pkg::STAT_OK;
      res_pid_q     <= '0;
      res_jid_q     <= '0;
      res_st_q      <= '0;
      res_slot_q    <= '0;
    end else begin
      rd_live_q <= live_q[rd_addr];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          idx_q     <= '0;
          chk_vld_q <= 1'b0;
          found_q   <= 1'b0;
          max_jid_q <= '0;
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (cmd_i.early) begin
              pend_ok_q     <= 1'b0;
              pend_status_q <= cmd_i.early_status;
              pend_pid_q    <= '0;
              pend_jid_q    <= '0;
              pend_st_q     <= '0;
              pend_slot_q   <= '0;
              state_q       <= S_DONE;
            end else if (cmd_i.mode == jte_pkg::MODE_READ) begin
              state_q <= S_RDSLOT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end

        S_RDSLOT: begin
          pend_ok_q     <= 1'b1;
          pend_status_q <= jte_pkg::STAT_OK;
          pend_pid_q    <= ent_pid;
          pend_jid_q    <= ent_jid;
          pend_st_q     <= ent_st;
          pend_slot_q   <= IdxW'(cmd_q.sel);
          state_q       <= S_DONE;
        end

        S_SCAN: begin
          // Reads are issued one slot per cycle; each is checked in the following cycle.
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          chk_vld_q <= issue;
          chk_idx_q <= idx_q[IdxW-1:0];
          // The running maximum skips only the slot that a delete removes.
          if (chk_vld_q && !hit_now && (ent_jid > max_jid_q)) begin
            max_jid_q <= ent_jid;
          end
          if (hit_now) begin
            found_q   <= 1'b1;
            hit_idx_q <= chk_idx_q;
            hit_pid_q <= ent_pid;
            hit_jid_q <= ent_jid;
            hit_st_q  <= ent_st;
          end
          if ((!is_del && hit_now) || (is_del && last_now && (found_q || hit_now))) begin
            state_q <= S_APPLY;
          end else if (last_now) begin
            pend_ok_q     <= 1'b0;
            pend_status_q <= (cmd_q.mode == jte_pkg::MODE_ADD) ? jte_pkg::STAT_FULL
                                                               : jte_pkg::STAT_NONE;
            pend_pid_q    <= '0;
            pend_jid_q    <= '0;
            pend_st_q     <= '0;
            pend_slot_q   <= '0;
            state_q       <= S_DONE;
          end
        end

        S_APPLY: begin
          pend_ok_q     <= 1'b1;
          pend_status_q <= jte_pkg::STAT_OK;
          pend_slot_q   <= hit_idx_q;
          unique case (cmd_q.mode) inside
            jte_pkg::MODE_ADD: begin
              pend_pid_q        <= cmd_q.pid[PidW-1:0];
              pend_jid_q        <= next_jid_q;
              pend_st_q         <= cmd_q.nst;
              live_q[hit_idx_q] <= 1'b1;
              next_jid_q        <= (jid_inc > JidW'(TableEntries)) ? JidW'(1) : jid_inc;
            end
            jte_pkg::MODE_DEL: begin
              pend_pid_q        <= hit_pid_q;
              pend_jid_q        <= hit_jid_q;
              pend_st_q         <= hit_st_q;
              live_q[hit_idx_q] <= 1'b0;
              next_jid_q        <= max_jid_q + 1'b1;
            end
            jte_pkg::MODE_SET_PID, jte_pkg::MODE_SET_JID: begin
              pend_pid_q <= hit_pid_q;
              pend_jid_q <= hit_jid_q;
              pend_st_q  <= cmd_q.nst;
            end
            default: begin
              pend_pid_q <= hit_pid_q;
              pend_jid_q <= hit_jid_q;
              pend_st_q  <= hit_st_q;
            end
          endcase
          state_q <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            ok_q        <= pend_ok_q;
            status_q    <= pend_status_q;
            res_pid_q   <= jte_pkg::PID_W'(pend_pid_q);
            res_jid_q   <= pend_jid_q;
            res_st_q    <= pend_st_q;
            res_slot_q  <= jte_pkg::SLOT_W'(pend_slot_q);
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign status_o    = status_q;
  assign res_pid_o   = res_pid_q;
  assign res_jid_o   = res_jid_q;
  assign res_state_o = res_st_q;
  assign res_slot_o  = res_slot_q;

endmodule

FILE: design/job_table_engine_core.sv
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_ready_o   mode_i, proc_id_i, job_num_i,
//                                                new_state_i, slot_sel_i
// response  out        out_valid_o / out_ready_i ok_o, status_o, res_pid_o,
//                                                res_jid_o, res_state_o, res_slot_o
//
// A request that walks the table reads one slot per cycle from the table memory in the
// back end, plus dispatch, update and hand-off; a slot read and a request rejected on its
// key skip the walk through the table.
// Reset empties the table through per-slot live bits at once and sets the next job id to 1.
// A two-entry queue takes requests while the back end works, and the response register
// lets the back end finish a request while the previous response waits.
module job_table_engine_core #(
  parameter int TableEntries = jte_pkg::TABLE_ENTRIES,
  parameter int PidBits      = jte_pkg::PID_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   mode_i,
  input  logic [jte_pkg::PID_W-1:0]    proc_id_i,
  input  logic [jte_pkg::JID_W-1:0]    job_num_i,
  input  logic [jte_pkg::STATE_W-1:0]  new_state_i,
  input  logic [jte_pkg::SEL_W-1:0]    slot_sel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic [1:0]                   status_o,
  output logic [jte_pkg::PID_W-1:0]    res_pid_o,
  output logic [jte_pkg::JID_W-1:0]    res_jid_o,
  output logic [jte_pkg::STATE_W-1:0]  res_state_o,
  output logic [jte_pkg::SLOT_W-1:0]   res_slot_o
);

  logic          push_valid, push_ready;
  jte_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  jte_pkg::cmd_t pop_cmd;

  jte_front #(
    .TableEntries(TableEntries),
    .PidBits     (PidBits)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .proc_id_i   (proc_id_i),
    .job_num_i   (job_num_i),
    .new_state_i (new_state_i),
    .slot_sel_i  (slot_sel_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  jte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  jte_back #(
    .TableEntries(TableEntries),
    .PidBits     (PidBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(pop_valid),
    .cmd_ready_o(pop_ready),
    .cmd_i      (pop_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ok_o       (ok_o),
    .status_o   (status_o),
    .res_pid_o  (res_pid_o),
    .res_jid_o  (res_jid_o),
    .res_state_o(res_state_o),
    .res_slot_o (res_slot_o)
  );

endmodule

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jte_pkg::*;

  localparam logic [STATE_W-1:0] ST_UNDEF = 2'd0;
  localparam logic [STATE_W-1:0] ST_BG    = 2'd2;
  localparam logic [STATE_W-1:0] ST_STOP  = 2'd3;
  localparam logic [PID_W-1:0]   PID_MAX  = '1;
  localparam logic [JID_W-1:0]   JID_MAX  = '1;
  localparam int                 STALL_LIMIT = 4000;

  typedef struct packed {
    logic               ok;
    logic [1:0]         status;
    logic [PID_W-1:0]   pid;
    logic [JID_W-1:0]   jid;
    logic [STATE_W-1:0] state;
    logic [SLOT_W-1:0]  slot;
  } job_resp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic [2:0]         mode = MODE_ADD;
  logic [PID_W-1:0]   proc_id = '0;
  logic [JID_W-1:0]   job_num = '0;
  logic [STATE_W-1:0] new_state = '0;
  logic [SEL_W-1:0]   slot_sel = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic               ok_o;
  logic [1:0]         status_o;
  logic [PID_W-1:0]   res_pid_o;
  logic [JID_W-1:0]   res_jid_o;
  logic [STATE_W-1:0] res_state_o;
  logic [SLOT_W-1:0]  res_slot_o;

  // Shadow copy of the job table, updated in the order requests are taken.
  logic [PID_W-1:0]   tbl_pid   [TABLE_ENTRIES];
  logic [JID_W-1:0]   tbl_jid   [TABLE_ENTRIES];
  logic [STATE_W-1:0] tbl_state [TABLE_ENTRIES];
  logic [JID_W-1:0]   nxt_jid;

  job_resp_t pending_resp[$];
  job_resp_t want_resp;
  bit        idle_on = 1'b1;
  int        rx_hold_cycles = 0;
  int        error_count = 0;
  int        sent_count = 0;
  int        checked_count = 0;
  int        status_seen[4] = '{0, 0, 0, 0};
  int        quiet_cycles = 0;

  job_table_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode),
    .proc_id_i   (proc_id),
    .job_num_i   (job_num),
    .new_state_i (new_state),
    .slot_sel_i  (slot_sel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .ok_o        (ok_o),
    .status_o    (status_o),
    .res_pid_o   (res_pid_o),
    .res_jid_o   (res_jid_o),
    .res_state_o (res_state_o),
    .res_slot_o  (res_slot_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int slot_of_pid(input logic [PID_W-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_pid[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int slot_of_jid(input logic [JID_W-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_jid[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic job_resp_t entry_view(input int s);
    job_resp_t r;
    r.ok     = 1'b1;
    r.status = STAT_OK;
    r.pid    = tbl_pid[s];
    r.jid    = tbl_jid[s];
    r.state  = tbl_state[s];
    r.slot   = s[SLOT_W-1:0];
    return r;
  endfunction

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic job_resp_t job_table_apply(input logic [2:0] op,
                                                input logic [PID_W-1:0] pid,
                                                input logic [JID_W-1:0] jid,
                                                input logic [STATE_W-1:0] nst,
                                                input logic [SEL_W-1:0] sel);
    job_resp_t        r;
    int               hit;
    logic [JID_W-1:0] top;
    r   = '0;
    hit = -1;
    top = '0;
    case (op)
      MODE_ADD: begin
        if (pid == '0) begin
          r.status = STAT_KEY;
        end else begin
          hit = slot_of_pid('0);
          if (hit < 0) begin
            r.status = STAT_FULL;
          end else begin
            tbl_pid[hit]   = pid;
            tbl_state[hit] = nst;
            tbl_jid[hit]   = nxt_jid;
            nxt_jid        = nxt_jid + 1'b1;
            if (nxt_jid > TABLE_ENTRIES) nxt_jid = JID_W'(1);
            r = entry_view(hit);
          end
        end
      end
      MODE_DEL: begin
        if (pid == '0) begin
          r.status = STAT_KEY;
        end else begin
          hit = slot_of_pid(pid);
          if (hit < 0) begin
            r.status = STAT_NONE;
          end else begin
            // The response shows the entry as it stood before it was freed.
            r = entry_view(hit);
            tbl_pid[hit]   = '0;
            tbl_jid[hit]   = '0;
            tbl_state[hit] = ST_UNDEF;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (tbl_jid[i] > top) top = tbl_jid[i];
            end
            nxt_jid = top + 1'b1;
          end
        end
      end
      MODE_SET_PID, MODE_FIND_PID: begin
        if (pid == '0) begin
          r.status = STAT_KEY;
        end else begin
          hit = slot_of_pid(pid);
          if (hit < 0) begin
            r.status = STAT_NONE;
          end else begin
            if (op == MODE_SET_PID) tbl_state[hit] = nst;
            r = entry_view(hit);
          end
        end
      end
      MODE_SET_JID, MODE_FIND_JID: begin
        if (jid == '0) begin
          r.status = STAT_KEY;
        end else begin
          hit = slot_of_jid(jid);
          if (hit < 0) begin
            r.status = STAT_NONE;
          end else begin
            if (op == MODE_SET_JID) tbl_state[hit] = nst;
            r = entry_view(hit);
          end
        end
      end
      MODE_FG: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (hit < 0 && tbl_state[i] == ST_FG) hit = i;
        end
        if (hit < 0) r.status = STAT_NONE;
        else r = entry_view(hit);
      end
      default: begin
        if (int'(sel) >= TABLE_ENTRIES) r.status = STAT_NONE;
        else r = entry_view(int'(sel));
      end
    endcase
    return r;
  endfunction

  // Offers one request, holding it until the block takes it, then records the
  // response it must produce. Called and returning on a rising edge.
  task automatic send_request(input logic [2:0] op, input logic [PID_W-1:0] pid,
                              input logic [JID_W-1:0] jid, input logic [STATE_W-1:0] nst,
                              input logic [SEL_W-1:0] sel);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode      <= op;
    proc_id   <= pid;
    job_num   <= jid;
    new_state <= nst;
    slot_sel  <= sel;
    in_valid  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_resp.push_back(job_table_apply(op, pid, jid, nst, sel));
    sent_count++;
  endtask

  function automatic logic [PID_W-1:0] pick_pid(input bit fresh);
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, TABLE_ENTRIES - 1);
    if (r < 8) return '0;
    if (!fresh && r < 75 && tbl_pid[s] != '0) return tbl_pid[s];
    if (r < 88) return PID_W'($urandom_range(1, 40));
    return PID_W'($urandom);
  endfunction

  function automatic logic [JID_W-1:0] pick_jid();
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, TABLE_ENTRIES - 1);
    if (r < 8) return '0;
    if (r < 75 && tbl_jid[s] != '0) return tbl_jid[s];
    if (r < 90) return JID_W'($urandom_range(1, 20));
    return JID_W'($urandom);
  endfunction

  // Mostly keys taken from live entries so lookups, updates and deletes hit, with adds
  // slightly more frequent than deletes so the table keeps churning.
  task automatic issue_random_request();
    int         r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 20)      op = MODE_ADD;
    else if (r < 36) op = MODE_DEL;
    else if (r < 48) op = MODE_SET_PID;
    else if (r < 60) op = MODE_SET_JID;
    else if (r < 70) op = MODE_FIND_PID;
    else if (r < 80) op = MODE_FIND_JID;
    else if (r < 90) op = MODE_FG;
    else             op = MODE_READ;
    send_request(op, pick_pid(op == MODE_ADD), pick_jid(), STATE_W'($urandom_range(0, 3)),
                 SEL_W'($urandom_range(0, 15)));
  endtask

  task automatic test_empty_table_and_zero_keys();
    send_request(MODE_READ, '0, '0, '0, 4'd15);
    send_request(MODE_FG, PID_MAX, JID_MAX, ST_FG, '0);
    send_request(MODE_FIND_PID, PID_MAX, '0, '0, '0);
    send_request(MODE_ADD, '0, JID_MAX, ST_STOP, 4'd15);
    send_request(MODE_DEL, '0, 16'd1, '0, '0);
    send_request(MODE_SET_PID, '0, 16'd1, ST_BG, '0);
    send_request(MODE_SET_JID, PID_MAX, '0, ST_BG, '0);
    send_request(MODE_FIND_PID, '0, 16'd1, '0, '0);
    send_request(MODE_FIND_JID, 22'd1, '0, '0, '0);
  endtask

  task automatic test_duplicates_and_state_updates();
    send_request(MODE_ADD, PID_MAX, '0, ST_FG, '0);
    send_request(MODE_ADD, 22'd1, '0, ST_BG, '0);
    // The same pid added twice lands in two slots; lookups see the lower one.
    send_request(MODE_ADD, 22'd1, '0, ST_STOP, '0);
    send_request(MODE_FG, '0, '0, '0, '0);
    send_request(MODE_SET_PID, PID_MAX, '0, ST_STOP, '0);
    send_request(MODE_FG, '0, '0, '0, '0);
    send_request(MODE_SET_JID, '0, 16'd2, ST_FG, '0);
    send_request(MODE_FIND_JID, '0, JID_MAX, '0, '0);
    send_request(MODE_FIND_PID, 22'd1, '0, '0, '0);
    send_request(MODE_DEL, 22'd1, '0, '0, '0);
    send_request(MODE_FIND_PID, 22'd1, '0, '0, '0);
    send_request(MODE_READ, '0, '0, '0, 4'd1);
    send_request(MODE_DEL, PID_MAX, '0, '0, '0);
    send_request(MODE_DEL, 22'd1, '0, '0, '0);
  endtask

  task automatic test_table_full();
    logic [PID_W-1:0] pid;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      pid = (i == 0) ? PID_MAX : PID_W'(22'h2A5A5 + i);
      send_request(MODE_ADD, pid, JID_W'($urandom), STATE_W'(i), SEL_W'($urandom));
    end
    send_request(MODE_ADD, 22'h123, '0, ST_BG, '0);
    send_request(MODE_READ, '0, '0, '0, 4'd15);
    // Freeing a slot while job 16 is still live makes the next job id 17.
    send_request(MODE_DEL, PID_W'(22'h2A5A5 + 7), '0, '0, '0);
    send_request(MODE_ADD, 22'h456, '0, ST_FG, '0);
    send_request(MODE_ADD, 22'h789, '0, ST_FG, '0);
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    idle_on = with_idle;
    repeat (count) issue_random_request();
  endtask

  // The receiver stops taking responses while requests keep coming back to back,
  // so the internal queue fills and the block has to deassert its input ready.
  task automatic test_output_stall();
    idle_on        = 1'b0;
    rx_hold_cycles = 300;
    repeat (14) issue_random_request();
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_pid[i]   = '0;
      tbl_jid[i]   = '0;
      tbl_state[i] = ST_UNDEF;
    end
    nxt_jid = JID_W'(1);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table_and_zero_keys();
    test_duplicates_and_state_updates();
    test_table_full();
    test_random_traffic(330, 1'b1);
    test_random_traffic(150, 1'b0);
    test_output_stall();
    test_random_traffic(180, 1'b1);
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Covered %0d requests over all eight modes, %0d responses checked.",
             sent_count, checked_count);
    $display("Status mix: ok %0d, zero key %0d, not found %0d, table full %0d.",
             status_seen[STAT_OK], status_seen[STAT_KEY], status_seen[STAT_NONE],
             status_seen[STAT_FULL]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Response side: a random stall before each response, or a long hold when asked.
  initial begin
    int hold;
    wait (rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        hold           = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        hold = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_resp.size() == 0) begin
        error_count++;
        $display("%0t: response with no request outstanding, expected none, actual pid %0h",
                 $realtime, res_pid_o);
      end else begin
        want_resp = pending_resp.pop_front();
        check_field("ok", 32'(want_resp.ok), 32'(ok_o));
        check_field("status", 32'(want_resp.status), 32'(status_o));
        check_field("res_pid", 32'(want_resp.pid), 32'(res_pid_o));
        check_field("res_jid", 32'(want_resp.jid), 32'(res_jid_o));
        check_field("res_state", 32'(want_resp.state), 32'(res_state_o));
        check_field("res_slot", 32'(want_resp.slot), 32'(res_slot_o));
        status_seen[want_resp.status]++;
        checked_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding.",
               STALL_LIMIT, pending_resp.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
